### rtl/core/swfc_pkg.sv
// Shared constants and types for the sensor window fault check.
package swfc_pkg;

	localparam int WINDOW_LEN = 100;
	localparam int ADDR_W     = $clog2(WINDOW_LEN);
	localparam int PTR_W      = $clog2(WINDOW_LEN + 1);
	localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
	localparam int SAMPLE_W   = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t FLT_NORMAL  = 2'd0;
	localparam status_t FLT_BREAK   = 2'd1;
	localparam status_t FLT_SHORT   = 2'd2;
	localparam status_t FLT_FLICKER = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_LOW_LIMIT     = 2'd0;
	localparam cfg_idx_t CFG_HIGH_LIMIT    = 2'd1;
	localparam cfg_idx_t CFG_MAX_OUT_COUNT = 2'd2;
	localparam cfg_idx_t CFG_MAX_SPREAD    = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] low_limit;
		logic signed [SAMPLE_W-1:0] high_limit;
		logic [6:0]                 max_out_count;
		logic [7:0]                 max_spread;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		low_limit:     8'sd0,
		high_limit:    8'sd100,
		max_out_count: 7'd10,
		max_spread:    8'd20
	};

endpackage

### rtl/core/swfc_window.sv
// Sample window memory: one write port, one registered read port.
module swfc_window (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [swfc_pkg::ADDR_W-1:0]         wr_addr,
	input  logic signed [swfc_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                                rd_en,
	input  logic [swfc_pkg::ADDR_W-1:0]         rd_addr,
	output logic signed [swfc_pkg::SAMPLE_W-1:0] rd_data
);
	import swfc_pkg::*;

	logic signed [SAMPLE_W-1:0] mem_q [WINDOW_LEN];
	logic signed [SAMPLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/swfc_eval.sv
// Scan accumulators (low and high counts, minimum, maximum) and fault decision.
module swfc_eval (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 data_vld,
	input  logic                                 data_first,
	input  logic signed [swfc_pkg::SAMPLE_W-1:0] data,
	input  swfc_pkg::cfg_t                       cfg,
	output swfc_pkg::status_t                    code
);
	import swfc_pkg::*;

	logic [CNT_W-1:0]           n_low_q;
	logic [CNT_W-1:0]           n_high_q;
	logic signed [SAMPLE_W-1:0] lo_q;
	logic signed [SAMPLE_W-1:0] hi_q;
	logic                       is_low;
	logic                       is_high;
	logic [CNT_W-1:0]           n_low_base;
	logic [CNT_W-1:0]           n_high_base;
	logic [SAMPLE_W:0]          spread;

	// A sample below the low limit counts only as low.
	assign is_low      = data < cfg.low_limit;
	assign is_high     = !is_low && (data > cfg.high_limit);
	assign n_low_base  = data_first ? '0 : n_low_q;
	assign n_high_base = data_first ? '0 : n_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_low_q  <= '0;
			n_high_q <= '0;
		end else if (data_vld) begin
			n_low_q  <= n_low_base + CNT_W'(is_low);
			n_high_q <= n_high_base + CNT_W'(is_high);
		end
	end

	always_ff @(posedge clk) begin
		if (data_vld) begin
			if (data_first || data < lo_q) begin
				lo_q <= data;
			end
			if (data_first || data > hi_q) begin
				hi_q <= data;
			end
		end
	end

	// Maximum is never below minimum, so the difference fits in the low bits.
	assign spread = {hi_q[SAMPLE_W-1], hi_q} - {lo_q[SAMPLE_W-1], lo_q};

	always_comb begin
		code = FLT_NORMAL;
		if (n_high_q > CNT_W'(cfg.max_out_count)) begin
			code = FLT_BREAK;
		end
		if (n_low_q > CNT_W'(cfg.max_out_count)) begin
			code = FLT_SHORT;
		end
		if (spread > {1'b0, cfg.max_spread}) begin
			code = FLT_FLICKER;
		end
	end

endmodule

### rtl/core/sensor_window_fault_check_top.sv
// An item that does not check needs no scan: it goes from accept straight to the result state.
// Once the window has wrapped, each item scans the window memory one entry per
// cycle through its single read port: the item is accepted, all 100 entries are read,
// the last read data is registered and then the decision is made, one item at a time.
// Reset clears the write position, the full flag, the fault status and the
// configuration registers; the window memory is not cleared.
module sensor_window_fault_check_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [swfc_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [swfc_pkg::STATUS_W-1:0]        status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swfc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import swfc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              full_q;
	logic              chk_q;
	logic [ADDR_W-1:0] scan_q;
	status_t           fault_q;
	logic              out_valid_q;
	logic              rd_vld_s1;
	logic              rd_first_s1;

	logic                       in_xfer;
	logic                       wrap;
	logic [ADDR_W-1:0]          wr_addr;
	logic                       rd_en;
	logic                       out_free;
	logic signed [SAMPLE_W-1:0] rd_data;
	status_t                    code;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign in_xfer   = in_valid && in_ready;
	assign wrap      = ptr_q == PTR_W'(WINDOW_LEN);
	assign wr_addr   = wrap ? '0 : ptr_q[ADDR_W-1:0];
	assign rd_en     = state_q == ST_SCAN;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign status    = fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOW_LIMIT:     cfg_q.low_limit     <= cfg_data;
				CFG_HIGH_LIMIT:    cfg_q.high_limit    <= cfg_data;
				CFG_MAX_OUT_COUNT: cfg_q.max_out_count <= cfg_data[6:0];
				CFG_MAX_SPREAD:    cfg_q.max_spread    <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			full_q      <= 1'b0;
			chk_q       <= 1'b0;
			scan_q      <= '0;
			fault_q     <= FLT_NORMAL;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_first_s1 <= rd_en && scan_q == '0;
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ptr_q  <= PTR_W'(wr_addr) + PTR_W'(1);
						full_q <= full_q || wrap;
						chk_q  <= full_q || wrap;
						scan_q <= '0;
						state_q <= (full_q || wrap) ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + ADDR_W'(1);
					if (scan_q == ADDR_W'(WINDOW_LEN - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// The status register is the output payload, so it changes
					// only once the previous result has been transferred.
					if (out_free) begin
						if (chk_q && code != FLT_NORMAL) begin
							fault_q <= code;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	swfc_window u_window (
		.clk     (clk),
		.wr_en   (in_xfer),
		.wr_addr (wr_addr),
		.wr_data (sample),
		.rd_en   (rd_en),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	swfc_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_vld   (rd_vld_s1),
		.data_first (rd_first_s1),
		.data       (rd_data),
		.cfg        (cfg_q),
		.code       (code)
	);

	// Once a fault is raised the status never goes back to normal.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != FLT_NORMAL |=> fault_q != FLT_NORMAL)
		else $error("fault status returned to normal");

	// The window is only scanned after it has been filled once.
	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> full_q)
		else $error("window scanned before it was full");

	// No sample is written while scan data is still arriving.
	a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> !in_xfer)
		else $error("window written during a scan");

	// The first read data of a scan is always followed by more read data, not by a new first.
	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		rd_first_s1 |=> rd_vld_s1 && !rd_first_s1)
		else $error("scan restarted unexpectedly");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sensor window fault check block.
module testbench;
	import swfc_pkg::*;

	localparam int QUIET_LIMIT   = 4000;
	localparam int PRESSURE_HOLD = 600;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	status_t                    status;
	logic                       cfg_valid;
	logic                       cfg_ready;
	cfg_idx_t                   cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	// Our own copy of the window, the write position and the limits.
	logic signed [SAMPLE_W-1:0] window_copy [WINDOW_LEN];
	int                         wr_pos     = 0;
	bit                         wrapped    = 1'b0;
	status_t                    fault_now  = FLT_NORMAL;
	logic signed [SAMPLE_W-1:0] low_lim    = CFG_RESET.low_limit;
	logic signed [SAMPLE_W-1:0] high_lim   = CFG_RESET.high_limit;
	logic [6:0]                 count_lim  = CFG_RESET.max_out_count;
	logic [7:0]                 spread_lim = CFG_RESET.max_spread;

	status_t status_due [$];
	int      bad_results  = 0;
	int      quiet_cycles = 0;
	int      hold_cycles  = 0;
	bit      steady       = 1'b0;

	sensor_window_fault_check_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(5, 150);
	endfunction

	function automatic int clamp8(input int v);
		if (v < -128)
			return -128;
		if (v > 127)
			return 127;
		return v;
	endfunction

	// Store the sample, then rescan the whole window once it has wrapped.
	function automatic status_t scan_window(input logic signed [SAMPLE_W-1:0] value);
		int n_low;
		int n_high;
		int lo;
		int hi;
		int v;
		status_t code;
		n_low  = 0;
		n_high = 0;
		if (wr_pos >= WINDOW_LEN) begin
			wr_pos  = 0;
			wrapped = 1'b1;
		end
		window_copy[wr_pos] = value;
		wr_pos++;
		if (wrapped) begin
			lo   = window_copy[0];
			hi   = lo;
			code = FLT_NORMAL;
			for (int k = 0; k < WINDOW_LEN; k++) begin
				v = window_copy[k];
				if (v < int'(low_lim))
					n_low++;
				else if (v > int'(high_lim))
					n_high++;
				if (v < lo)
					lo = v;
				if (v > hi)
					hi = v;
			end
			if (n_high > int'(count_lim))
				code = FLT_BREAK;
			if (n_low > int'(count_lim))
				code = FLT_SHORT;
			if (hi - lo > int'(spread_lim))
				code = FLT_FLICKER;
			if (code != FLT_NORMAL)
				fault_now = code;
		end
		return fault_now;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_LOW_LIMIT:     low_lim    = data;
			CFG_HIGH_LIMIT:    high_lim   = data;
			CFG_MAX_OUT_COUNT: count_lim  = data[6:0];
			CFG_MAX_SPREAD:    spread_lim = data;
			default: ;
		endcase
	endtask

	// Only called while the block is idle.
	task automatic set_limits(input int lo, input int hi, input int cnt, input int spread);
		write_reg(CFG_LOW_LIMIT, lo[7:0]);
		write_reg(CFG_HIGH_LIMIT, hi[7:0]);
		write_reg(CFG_MAX_OUT_COUNT, cnt[7:0]);
		write_reg(CFG_MAX_SPREAD, spread[7:0]);
		cfg_valid <= 1'b0;
	endtask

	// Valid stays high after a transfer so that back-to-back samples need no gap;
	// every caller that lets time pass lowers it first.
	task automatic send_sample(input int value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value[7:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		status_due.push_back(scan_window(value[7:0]));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (status_due.size() != 0);
	endtask

	// Reset limits: low 0, high 100, ten outliers allowed, spread 20.
	// The band keeps every check normal, with the spread exactly on the limit.
	task automatic test_reset_limits();
		for (int k = 0; k < 115; k++) begin
			if (k == 50)
				send_sample(30);
			else if (k == 51)
				send_sample(50);
			else
				send_sample($urandom_range(30, 50));
		end
		wait_idle();
	endtask

	task automatic test_high_count();
		set_limits(-128, 50, 10, 255);
		repeat (10) send_sample(51);
		send_sample(50);
		send_sample(51);
		send_sample(127);
		send_sample(-128);
		wait_idle();
	endtask

	// Too many low samples must win over too many high ones.
	task automatic test_low_count();
		set_limits(0, 50, 5, 255);
		send_sample(-1);
		send_sample(-128);
		send_sample(-64);
		send_sample(0);
		send_sample(-2);
		send_sample(-3);
		send_sample(-4);
		wait_idle();
	endtask

	// Low limit above high limit; a low sample is never counted as high too.
	task automatic test_crossed_limits();
		set_limits(100, -100, 255, 255);
		send_sample(120);
		send_sample(-120);
		send_sample(0);
		send_sample(100);
		wait_idle();
		set_limits(-128, -128, 0, 255);
		send_sample(-128);
		send_sample(-127);
		send_sample(5);
		wait_idle();
	endtask

	task automatic test_spread();
		set_limits(-128, 127, 100, 0);
		send_sample(3);
		send_sample(-3);
		wait_idle();
		set_limits(-128, 127, 0, 254);
		send_sample(127);
		send_sample(-128);
		send_sample(0);
		wait_idle();
	endtask

	// Each phase picks a temperature band and mostly limits around it (else random limits), with some noise.
	task automatic test_random_phases(input int phases, input int per_phase);
		int c;
		int w;
		int lo;
		int hi;
		int cnt;
		int spread;
		for (int p = 0; p < phases; p++) begin
			c = int'($urandom_range(0, 200)) - 100;
			w = $urandom_range(0, 30);
			if ($urandom_range(0, 3) == 0) begin
				lo     = int'($urandom_range(0, 255)) - 128;
				hi     = int'($urandom_range(0, 255)) - 128;
				cnt    = $urandom_range(0, 255);
				spread = $urandom_range(0, 255);
			end else begin
				lo = clamp8(c - int'($urandom_range(0, w + 8)));
				hi = clamp8(c + int'($urandom_range(0, w + 8)));
				case ($urandom_range(0, 3))
					0:       cnt = 0;
					1:       cnt = 100;
					default: cnt = $urandom_range(0, 30);
				endcase
				spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 2 * w + 10);
			end
			steady = (p == 2);
			set_limits(lo, hi, cnt, spread);
			for (int k = 0; k < per_phase; k++) begin
				if ($urandom_range(0, 99) < 85)
					send_sample(clamp8(c + int'($urandom_range(0, 2 * w)) - w));
				else
					send_sample(int'($urandom_range(0, 255)) - 128);
			end
			wait_idle();
		end
		steady = 1'b0;
	endtask

	// The receiver holds off for a long stretch while samples keep coming.
	task automatic test_backpressure();
		steady      = 1'b1;
		hold_cycles = PRESSURE_HOLD;
		repeat (12) send_sample(int'($urandom_range(0, 255)) - 128);
		steady = 1'b0;
		wait_idle();
	endtask

	initial begin
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		status_t due;
		if (arst_n && out_valid && out_ready) begin
			if (status_due.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("unexpected status transfer: got %0d, nothing pending", status);
			end else begin
				due = status_due.pop_front();
				if (status !== due) begin
					bad_results++;
					if (bad_results <= 10)
						$display("status mismatch: expected %0d, got %0d", due, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_LOW_LIMIT;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limits();
		test_high_count();
		test_low_count();
		test_crossed_limits();
		test_spread();
		test_random_phases(9, 50);
		test_backpressure();

		wait_idle();
		repeat (20) @(posedge clk);
		if (bad_results == 0 && status_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
